>>> hw/rtl/amgdi_pkg.sv
// Package for the direct-interpolation weight block: widths, stream layout,
// command/status structs between controller and datapath. No dependencies.
package amgdi_pkg;

   localparam int VAL_W  = 32;
   localparam int IDX_W  = 24;
   localparam int ACC_W  = 40;
   localparam int PROD_W = 64;
   localparam int NUM_W  = 64;
   localparam int CAND_W = VAL_W + IDX_W;

   localparam int REQ_TDATA_W = 88;
   localparam int RSP_TDATA_W = 56;

   localparam int MAX_ROW_ENTRIES_DEF = 32;
   localparam int FRACTION_BITS_DEF   = 16;

   typedef enum logic [1:0] {
      DSEL_ALPHA,
      DSEL_BETA,
      DSEL_WEIGHT
   } div_sel_type;

   typedef struct packed {
      logic        accept;
      logic        div_start;
      div_sel_type div_sel;
      logic        latch_alpha;
      logic        latch_beta;
      logic        diag_adj;
      logic        idx_clear;
      logic        idx_inc;
      logic        mem_rd;
      logic        mul;
      logic        push_coarse;
      logic        push_held;
      logic        push_last;
      logic        hold_new;
      logic        held_clear;
      logic        row_clear;
   } cmd_type;

   typedef struct packed {
      logic end_fire;
      logic end_coarse;
      logic div_busy;
      logic div_done;
      logic at_end;
      logic w_nonzero;
      logic held_valid;
      logic out_free;
   } sts_type;

endpackage

>>> hw/rtl/amg_direct_interpolation_weights.sv
// Top level of the classical AMG direct-interpolation weight block.
// Depends on amgdi_pkg, amgdi_ctrl, amgdi_datapath (with amgdi_div).
//
//  channel | dir | handshake          | payload
//  req_    | in  | tvalid/tready      | tdata (88b) matrix entry, tlast = row end
//  rsp_    | out | tvalid/tready      | tdata (56b) weight, tlast = last of row
//
// Flow: one entry per cycle while a row accumulates. At row end a coarse row
// emits its one weight; a fine row runs the alpha and beta divisions and the
// diagonal fix-up, then a weight division per buffered candidate and a flush,
// on the one-bit-a-cycle 64-step divider that all three divisions share.
// Reset: synchronous, active high; clears sums, counts and the controller.
// Stalls: a held rsp_ transfer stalls the replay, the flush or the coarse row
// whenever a further weight must go out; req_ is taken again once the row is done.
module amg_direct_interpolation_weights #(
   parameter int MAX_ROW_ENTRIES = amgdi_pkg::MAX_ROW_ENTRIES_DEF,
   parameter int FRACTION_BITS   = amgdi_pkg::FRACTION_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // row_is_coarse[0], row_coarse_index[24:1], entry_value[56:25],
   // entry_is_diagonal[57], entry_is_strong[58], neighbour_is_coarse[59],
   // neighbour_coarse_index[83:60], zero pad[87:84]
   input  logic [amgdi_pkg::REQ_TDATA_W-1:0] req_tdata,
   input  logic                              req_tlast,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // coarse_column[23:0], weight[55:24]
   output logic [amgdi_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   output logic                              rsp_tlast
);

   amgdi_pkg::cmd_type cmd;
   amgdi_pkg::sts_type sts;

   amgdi_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .sts   (sts),
      .cmd   (cmd)
   );

   amgdi_datapath #(
      .MAX_ROW_ENTRIES (MAX_ROW_ENTRIES),
      .FRACTION_BITS   (FRACTION_BITS)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .cmd        (cmd),
      .sts        (sts)
   );

   assign req_tready = cmd.accept;

   // the shared divider is never restarted mid-division
   a_div_start_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.div_start |-> !sts.div_busy) else $error("divider restarted while busy");

   // entries are only taken while no division runs
   a_accept_idle: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> !sts.div_busy) else $error("entry taken during division");

   // a weight is only loaded when the output register can take it
   a_push_free: assert property (@(posedge clock) disable iff (reset)
      (cmd.push_coarse || cmd.push_held) |-> sts.out_free)
      else $error("output register overwritten");

endmodule

>>> hw/rtl/amgdi_div.sv
// Restoring divider, one quotient bit a cycle, signed result saturated to 32 bits.
// Depends on amgdi_pkg.
module amgdi_div (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic                        num_neg,
   input  logic [amgdi_pkg::NUM_W-1:0] num_mag,
   input  logic                        den_neg,
   input  logic [amgdi_pkg::ACC_W-1:0] den_mag,
   output logic                        busy,
   output logic                        done,
   output logic signed [amgdi_pkg::VAL_W-1:0] result
);

   localparam int CNT_W = $clog2(amgdi_pkg::NUM_W);

   logic                          busy_ff, busy_in;
   logic                          done_ff, done_in;
   logic [CNT_W-1:0]              cnt_ff, cnt_in;
   logic [amgdi_pkg::ACC_W-1:0]   rem_ff, rem_in;
   logic [amgdi_pkg::NUM_W-1:0]   quo_ff, quo_in;
   logic [amgdi_pkg::ACC_W-1:0]   den_ff, den_in;
   logic                          neg_ff, neg_in;
   logic                          dz_ff, dz_in;
   logic [amgdi_pkg::ACC_W:0]     rem_sh;
   logic [amgdi_pkg::ACC_W:0]     rem_sub;

   assign rem_sh  = {rem_ff, quo_ff[amgdi_pkg::NUM_W-1]};
   assign rem_sub = rem_sh - {1'b0, den_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      neg_in  = neg_ff;
      dz_in   = dz_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         quo_in  = num_mag;
         den_in  = den_mag;
         neg_in  = num_neg ^ den_neg;
         dz_in   = (den_mag == '0);
      end else if (busy_ff) begin
         if (!rem_sub[amgdi_pkg::ACC_W]) begin
            rem_in = rem_sub[amgdi_pkg::ACC_W-1:0];
            quo_in = {quo_ff[amgdi_pkg::NUM_W-2:0], 1'b1};
         end else begin
            rem_in = rem_sh[amgdi_pkg::ACC_W-1:0];
            quo_in = {quo_ff[amgdi_pkg::NUM_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(amgdi_pkg::NUM_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
      neg_ff <= neg_in;
      dz_ff  <= dz_in;
   end

   // saturate the magnitude quotient into signed 32 bits
   always_comb begin
      if (dz_ff) begin
         result = '0;
      end else if (neg_ff) begin
         if (quo_ff > amgdi_pkg::NUM_W'(64'h8000_0000)) result = 32'sh8000_0000;
         else result = -$signed(quo_ff[amgdi_pkg::VAL_W-1:0]);
      end else begin
         if (quo_ff > amgdi_pkg::NUM_W'(64'h7FFF_FFFF)) result = 32'sh7FFF_FFFF;
         else result = $signed(quo_ff[amgdi_pkg::VAL_W-1:0]);
      end
   end

   assign busy = busy_ff;
   assign done = done_ff;

endmodule

>>> hw/rtl/amgdi_datapath.sv
// Datapath: row sums, candidate memory, coefficient and weight arithmetic,
// output register. Depends on amgdi_pkg and amgdi_div.
module amgdi_datapath #(
   parameter int MAX_ROW_ENTRIES = amgdi_pkg::MAX_ROW_ENTRIES_DEF,
   parameter int FRACTION_BITS   = amgdi_pkg::FRACTION_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   input  logic [amgdi_pkg::REQ_TDATA_W-1:0] req_tdata,
   input  logic                              req_tlast,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [amgdi_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   output logic                              rsp_tlast,
   input  amgdi_pkg::cmd_type                cmd,
   output amgdi_pkg::sts_type                sts
);

   localparam int CNT_W  = $clog2(MAX_ROW_ENTRIES + 1);
   localparam int ADDR_W = (MAX_ROW_ENTRIES > 1) ? $clog2(MAX_ROW_ENTRIES) : 1;
   localparam int ACC_W  = amgdi_pkg::ACC_W;
   localparam int VAL_W  = amgdi_pkg::VAL_W;
   localparam int IDX_W  = amgdi_pkg::IDX_W;

   function automatic logic signed [ACC_W-1:0] sat_add(
      input logic signed [ACC_W-1:0] a, input logic signed [ACC_W-1:0] b);
      logic signed [ACC_W:0] s;
      s = ACC_W'(0) + (ACC_W+1)'(a) + (ACC_W+1)'(b);
      if (s[ACC_W] != s[ACC_W-1])
         return s[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
      return s[ACC_W-1:0];
   endfunction

   function automatic logic [ACC_W-1:0] mag40(input logic signed [ACC_W-1:0] x);
      return x[ACC_W-1] ? ACC_W'(-x) : ACC_W'(x);
   endfunction

   // input fields
   logic                     in_row_coarse;
   logic [IDX_W-1:0]         in_row_index;
   logic signed [VAL_W-1:0]  in_value;
   logic                     in_diag, in_strong, in_nb_coarse;
   logic [IDX_W-1:0]         in_nb_index;
   logic                     fire;

   assign in_row_coarse = req_tdata[0];
   assign in_row_index  = req_tdata[24:1];
   assign in_value      = $signed(req_tdata[56:25]);
   assign in_diag       = req_tdata[57];
   assign in_strong     = req_tdata[58];
   assign in_nb_coarse  = req_tdata[59];
   assign in_nb_index   = req_tdata[83:60];
   assign fire          = req_tvalid && cmd.accept;

   logic signed [ACC_W-1:0] ap_ff, an_ff, gp_ff, gn_ff, diag_ff;
   logic [CNT_W-1:0]        count_ff, rd_idx_ff;
   logic [IDX_W-1:0]        row_index_ff;
   logic signed [VAL_W-1:0] alpha_ff, beta_ff;
   logic signed [amgdi_pkg::PROD_W-1:0] prod_ff;
   logic [IDX_W-1:0]        col_ff;
   logic                    held_valid_ff;
   logic [IDX_W-1:0]        held_col_ff;
   logic signed [VAL_W-1:0] held_w_ff;
   logic                    rsp_valid_ff;
   logic [amgdi_pkg::RSP_TDATA_W-1:0] rsp_data_ff;
   logic                    rsp_last_ff;

   logic [amgdi_pkg::CAND_W-1:0] cand_mem [MAX_ROW_ENTRIES];
   logic [amgdi_pkg::CAND_W-1:0] mem_q_ff;
   logic                         cand_wr;
   logic signed [VAL_W-1:0]      cand_val;

   assign cand_wr  = fire && !in_diag && in_strong && in_nb_coarse &&
                     (count_ff < CNT_W'(MAX_ROW_ENTRIES));
   assign cand_val = $signed(mem_q_ff[VAL_W-1:0]);

   always_ff @(posedge clock) begin
      if (cand_wr) cand_mem[count_ff[ADDR_W-1:0]] <= {in_nb_index, in_value};
      if (cmd.mem_rd) mem_q_ff <= cand_mem[rd_idx_ff[ADDR_W-1:0]];
   end

   // divider and its operand select
   logic                        div_num_neg, div_den_neg, div_busy, div_done;
   logic [amgdi_pkg::NUM_W-1:0] div_num;
   logic [ACC_W-1:0]            div_den;
   logic signed [VAL_W-1:0]     div_result;

   always_comb begin
      unique case (cmd.div_sel)
         amgdi_pkg::DSEL_ALPHA: begin
            div_num_neg = (an_ff > 0);
            div_num     = amgdi_pkg::NUM_W'(mag40(an_ff)) << FRACTION_BITS;
            div_den_neg = gn_ff[ACC_W-1];
            div_den     = mag40(gn_ff);
         end
         amgdi_pkg::DSEL_BETA: begin
            div_num_neg = (ap_ff > 0);
            div_num     = amgdi_pkg::NUM_W'(mag40(ap_ff)) << FRACTION_BITS;
            div_den_neg = gp_ff[ACC_W-1];
            div_den     = mag40(gp_ff);
         end
         default: begin
            div_num_neg = prod_ff[amgdi_pkg::PROD_W-1];
            div_num     = prod_ff[amgdi_pkg::PROD_W-1] ? amgdi_pkg::NUM_W'(-prod_ff)
                                                      : amgdi_pkg::NUM_W'(prod_ff);
            div_den_neg = diag_ff[ACC_W-1];
            div_den     = mag40(diag_ff);
         end
      endcase
   end

   amgdi_div u_div (
      .clock   (clock),
      .reset   (reset),
      .start   (cmd.div_start),
      .num_neg (div_num_neg),
      .num_mag (div_num),
      .den_neg (div_den_neg),
      .den_mag (div_den),
      .busy    (div_busy),
      .done    (div_done),
      .result  (div_result)
   );

   // row state
   always_ff @(posedge clock) begin
      if (reset || cmd.row_clear) begin
         ap_ff    <= '0;
         an_ff    <= '0;
         gp_ff    <= '0;
         gn_ff    <= '0;
         diag_ff  <= '0;
         count_ff <= '0;
      end else if (fire) begin
         if (in_diag) begin
            diag_ff <= ACC_W'(in_value);
         end else begin
            if (in_value > 0) ap_ff <= sat_add(ap_ff, ACC_W'(in_value));
            else an_ff <= sat_add(an_ff, ACC_W'(in_value));
            if (in_strong && in_nb_coarse) begin
               if (in_value > 0) gp_ff <= sat_add(gp_ff, ACC_W'(in_value));
               else gn_ff <= sat_add(gn_ff, ACC_W'(in_value));
            end
            if (cand_wr) count_ff <= count_ff + 1'b1;
         end
      end else if (cmd.diag_adj && gp_ff == '0) begin
         diag_ff <= sat_add(diag_ff, ap_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (fire && req_tlast) row_index_ff <= in_row_index;
      if (cmd.latch_alpha) alpha_ff <= div_result;
      if (cmd.latch_beta) beta_ff <= div_result;
      if (cmd.mul) begin
         prod_ff <= cand_val * (cand_val[VAL_W-1] ? alpha_ff : beta_ff);
         col_ff  <= mem_q_ff[amgdi_pkg::CAND_W-1:VAL_W];
      end
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.idx_clear) rd_idx_ff <= '0;
      else if (cmd.idx_inc) rd_idx_ff <= rd_idx_ff + 1'b1;
   end

   // one weight held back so the row's last one can be marked
   always_ff @(posedge clock) begin
      if (reset || cmd.held_clear) held_valid_ff <= 1'b0;
      else if (cmd.hold_new) held_valid_ff <= 1'b1;
      if (cmd.hold_new) begin
         held_col_ff <= col_ff;
         held_w_ff   <= div_result;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else if (cmd.push_coarse || cmd.push_held) rsp_valid_ff <= 1'b1;
      else if (rsp_tready) rsp_valid_ff <= 1'b0;
      if (cmd.push_coarse) begin
         rsp_data_ff <= {VAL_W'(1) << FRACTION_BITS, row_index_ff};
         rsp_last_ff <= 1'b1;
      end else if (cmd.push_held) begin
         rsp_data_ff <= {held_w_ff, held_col_ff};
         rsp_last_ff <= cmd.push_last;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

   assign sts.end_fire   = fire && req_tlast;
   assign sts.end_coarse = in_row_coarse;
   assign sts.div_busy   = div_busy;
   assign sts.div_done   = div_done;
   assign sts.at_end     = (rd_idx_ff == count_ff);
   assign sts.w_nonzero  = (div_result != '0);
   assign sts.held_valid = held_valid_ff;
   assign sts.out_free   = !rsp_valid_ff || rsp_tready;

endmodule

>>> hw/rtl/amgdi_ctrl.sv
// Controller: sequences row accumulation, coefficient divisions and the
// candidate replay. Depends on amgdi_pkg.
module amgdi_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  amgdi_pkg::sts_type sts,
   output amgdi_pkg::cmd_type cmd
);

   typedef enum logic [3:0] {
      S_ACCUM, S_COARSE, S_ALPHA_GO, S_ALPHA_WT, S_BETA_GO, S_BETA_WT,
      S_DIAG, S_READ, S_MUL, S_W_GO, S_W_WT, S_CHECK, S_FLUSH
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         S_ACCUM: begin
            cmd.accept = 1'b1;
            if (sts.end_fire) state_in = sts.end_coarse ? S_COARSE : S_ALPHA_GO;
         end
         S_COARSE: begin
            if (sts.out_free) begin
               cmd.push_coarse = 1'b1;
               cmd.row_clear   = 1'b1;
               state_in        = S_ACCUM;
            end
         end
         S_ALPHA_GO: begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = amgdi_pkg::DSEL_ALPHA;
            state_in      = S_ALPHA_WT;
         end
         S_ALPHA_WT: if (sts.div_done) state_in = S_BETA_GO;
         S_BETA_GO: begin
            cmd.latch_alpha = 1'b1;
            cmd.div_start   = 1'b1;
            cmd.div_sel     = amgdi_pkg::DSEL_BETA;
            state_in        = S_BETA_WT;
         end
         S_BETA_WT: if (sts.div_done) state_in = S_DIAG;
         S_DIAG: begin
            cmd.latch_beta = 1'b1;
            cmd.diag_adj   = 1'b1;
            cmd.idx_clear  = 1'b1;
            state_in       = S_READ;
         end
         S_READ: begin
            if (sts.at_end) begin
               state_in = S_FLUSH;
            end else begin
               cmd.mem_rd = 1'b1;
               state_in   = S_MUL;
            end
         end
         S_MUL: begin
            cmd.mul  = 1'b1;
            state_in = S_W_GO;
         end
         S_W_GO: begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = amgdi_pkg::DSEL_WEIGHT;
            state_in      = S_W_WT;
         end
         S_W_WT: if (sts.div_done) state_in = S_CHECK;
         S_CHECK: begin
            priority if (!sts.w_nonzero) begin
               cmd.idx_inc = 1'b1;
               state_in    = S_READ;
            end else if (!sts.held_valid) begin
               cmd.hold_new = 1'b1;
               cmd.idx_inc  = 1'b1;
               state_in     = S_READ;
            end else if (sts.out_free) begin
               cmd.push_held = 1'b1;
               cmd.hold_new  = 1'b1;
               cmd.idx_inc   = 1'b1;
               state_in      = S_READ;
            end
         end
         S_FLUSH: begin
            priority if (!sts.held_valid) begin
               cmd.row_clear = 1'b1;
               state_in      = S_ACCUM;
            end else if (sts.out_free) begin
               cmd.push_held  = 1'b1;
               cmd.push_last  = 1'b1;
               cmd.held_clear = 1'b1;
               cmd.row_clear  = 1'b1;
               state_in       = S_ACCUM;
            end
         end
         default: state_in = S_ACCUM;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_ACCUM;
      else state_ff <= state_in;
   end

endmodule
